FILE: rtl/ara_pkg.sv
package ara_pkg;

    localparam int ADDR_BITS = 16;
    localparam int HELD_BITS = 5;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [1:0] KIND_NEW   = 2'd0;
    localparam logic [1:0] KIND_LEFT  = 2'd1;
    localparam logic [1:0] KIND_RIGHT = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] range_first;
        logic [ADDR_BITS-1:0] range_last;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           merge_kind;
        logic [HELD_BITS-1:0] ranges_held;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_BITS-1:0] first;
        logic [ADDR_BITS-1:0] last;
    } t_range;

    // controller -> datapath, at most one bit set per cycle
    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic move;
        logic commit;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic accept;
        logic move_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/address_range_allocator.sv
// Address range allocator. Each input transaction claims an inclusive range
// range_first..range_last; it is rejected with status 1 if it overlaps a held
// range, otherwise it joins a left neighbor (ending just below range_first),
// else a right neighbor (starting just above range_last), else takes a new
// entry, which fails with status 2 when MAX_RANGES entries are held. One
// result transaction follows each request. Requests are handled one at a
// time; the one-read, one-write table memory is scanned and, for a stored
// item, then shifted one entry per cycle to keep the table sorted. The
// table needs no clearing after reset. A finished result sits in an output
// register, so the next request is taken while it waits.
module address_range_allocator
    import ara_pkg::*;
#(
    parameter int MAX_RANGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_req i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_rsp o_out_data,
    input  logic i_out_stall
);

    t_cmd cmd;
    t_sts sts;
    logic idle;

    ara_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    ara_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !idle;

endmodule

FILE: rtl/ara_dp.sv
module ara_dp
    import ara_pkg::*;
#(
    parameter int MAX_RANGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    input  logic i_out_stall,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_rsp o_out_data
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_RANGES);

    // range table, kept sorted by first address
    t_range r_mem [MAX_RANGES];

    logic [ADDR_BITS-1:0] r_f;
    logic [ADDR_BITS-1:0] r_l;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    t_range               r_rd_q;

    // scan results
    logic                 r_ovl;
    logic                 r_lfound;
    logic [IW-1:0]        r_lidx;
    logic [ADDR_BITS-1:0] r_lfirst;
    logic [CW-1:0]        r_leq;
    logic                 r_rfound;
    logic [IW-1:0]        r_ridx;
    logic [ADDR_BITS-1:0] r_rlast;
    logic                 r_rle;
    logic [CW-1:0]        r_nle;

    // decision
    logic [1:0]           r_status;
    logic [1:0]           r_kind;
    logic                 r_grow;
    logic [IW-1:0]        r_p;
    t_range               r_new;
    logic                 r_down;
    logic [IW-1:0]        r_src;
    logic [IW-1:0]        r_rem;

    logic                 r_out_valid;
    t_rsp                 r_out;

    logic                 re;
    logic [IW-1:0]        raddr;
    logic                 we;
    logic [IW-1:0]        waddr;
    t_range               wdata;

    logic [ADDR_BITS:0]   e_last_p1;
    logic [ADDR_BITS:0]   l_p1;
    logic                 hit_ovl;
    logic                 hit_left;
    logic                 hit_right;
    logic                 accept;
    logic [IW-1:0]        d_h;
    logic [IW-1:0]        d_p;
    logic [CW-1:0]        p_left;
    logic [CW-1:0]        p_right;

    // per-entry compares on the entry just read
    assign e_last_p1 = {1'b0, r_rd_q.last} + (ADDR_BITS+1)'(1);
    assign l_p1      = {1'b0, r_l} + (ADDR_BITS+1)'(1);
    assign hit_ovl   = !((r_l < r_rd_q.first) || (r_f > r_rd_q.last));
    assign hit_left  = (e_last_p1 == {1'b0, r_f});
    assign hit_right = (l_p1 == {1'b0, r_rd_q.first});

    assign accept  = !r_ovl && (r_lfound || r_rfound || (r_count != FULL_CNT));
    assign p_left  = CW'(r_lidx) + r_leq;
    assign p_right = r_nle - CW'(r_rle);

    always_comb begin
        if (r_lfound) begin
            d_h = r_lidx;
            d_p = p_left[IW-1:0];
        end else if (r_rfound) begin
            d_h = r_ridx;
            d_p = p_right[IW-1:0];
        end else begin
            // new entry: virtual hole at the end of the table
            d_h = r_count[IW-1:0];
            d_p = r_nle[IW-1:0];
        end
    end

    // memory port control
    always_comb begin
        re    = 1'b0;
        raddr = r_src;
        we    = 1'b0;
        waddr = r_p;
        wdata = r_new;
        if (i_cmd.scan) begin
            re    = (r_idx != r_count);
            raddr = r_idx[IW-1:0];
        end
        if (i_cmd.move) begin
            re    = (r_rem != '0);
            raddr = r_src;
            we    = r_rd_vld;
            waddr = r_down ? (r_rd_idx - IW'(1)) : (r_rd_idx + IW'(1));
            wdata = r_rd_q;
        end
        if (i_cmd.commit) begin
            we    = 1'b1;
            waddr = r_p;
            wdata = r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_q <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (i_cmd.scan || i_cmd.move) && re;
            if (i_cmd.commit && r_grow) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_f      <= i_req.range_first;
            r_l      <= i_req.range_last;
            r_idx    <= '0;
            r_ovl    <= 1'b0;
            r_lfound <= 1'b0;
            r_rfound <= 1'b0;
            r_leq    <= '0;
            r_nle    <= '0;
        end
        if (i_cmd.scan) begin
            if (re) begin
                r_idx    <= r_idx + CW'(1);
                r_rd_idx <= r_idx[IW-1:0];
            end
            if (r_rd_vld) begin
                if (hit_ovl) begin
                    r_ovl <= 1'b1;
                end
                if (!r_lfound && hit_left) begin
                    r_lfound <= 1'b1;
                    r_lidx   <= r_rd_idx;
                    r_lfirst <= r_rd_q.first;
                end else if (r_lfound && (r_rd_q.first == r_lfirst)) begin
                    // equal first addresses after the left hit stay ahead of it
                    r_leq <= r_leq + CW'(1);
                end
                if (!r_rfound && hit_right) begin
                    r_rfound <= 1'b1;
                    r_ridx   <= r_rd_idx;
                    r_rlast  <= r_rd_q.last;
                    r_rle    <= (r_rd_q.first <= r_f);
                end
                if (r_rd_q.first <= r_f) begin
                    r_nle <= r_nle + CW'(1);
                end
            end
        end
        if (i_cmd.decide) begin
            r_p    <= d_p;
            r_down <= (d_p >= d_h);
            r_src  <= (d_p >= d_h) ? (d_h + IW'(1)) : (d_h - IW'(1));
            r_rem  <= (d_p >= d_h) ? (d_p - d_h) : (d_h - d_p);
            r_grow <= 1'b0;
            r_kind <= KIND_NEW;
            r_new  <= '{first: r_f, last: r_l};
            if (r_ovl) begin
                r_status <= STATUS_OVERLAP;
            end else if (r_lfound) begin
                r_status <= STATUS_OK;
                r_kind   <= KIND_LEFT;
                r_new    <= '{first: r_lfirst, last: r_l};
            end else if (r_rfound) begin
                r_status <= STATUS_OK;
                r_kind   <= KIND_RIGHT;
                r_new    <= '{first: r_f, last: r_rlast};
            end else if (r_count == FULL_CNT) begin
                r_status <= STATUS_FULL;
            end else begin
                r_status <= STATUS_OK;
                r_grow   <= 1'b1;
            end
        end
        if (i_cmd.move && re) begin
            r_src    <= r_down ? (r_src + IW'(1)) : (r_src - IW'(1));
            r_rem    <= r_rem - IW'(1);
            r_rd_idx <= r_src;
        end
        if (i_cmd.emit) begin
            r_out.status      <= r_status;
            r_out.merge_kind  <= r_kind;
            r_out.ranges_held <= HELD_BITS'(r_count);
        end
    end

    assign o_sts.scan_done = (r_idx == r_count) && !r_rd_vld;
    assign o_sts.accept    = accept;
    assign o_sts.move_done = (r_rem == '0) && !r_rd_vld;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("range count beyond capacity");

    a_grow_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_grow) |-> (r_count != FULL_CNT))
        else $error("new entry committed into a full table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.emit)
        else $error("result overwritten while stalled");

    a_grow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_grow) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("count did not advance on new entry");
`endif

endmodule

FILE: rtl/ara_ctrl.sv
module ara_ctrl
    import ara_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_idle
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_MOVE   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.accept ? S_MOVE : S_DONE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                if (i_sts.move_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

FILE: bench/tb.sv
module tb;
    import ara_pkg::*;

    localparam int MAX_RANGES = 16;

    // Mirror of the allocation table. Updated when a request transaction is
    // accepted; the expected response is queued until the block returns it.
    class alloc_scoreboard;
        t_range ranges[$];
        t_rsp   expected[$];
        int     capacity;
        int     errors;

        function new(int cap);
            capacity = cap;
            errors   = 0;
        endfunction

        function void note_request(t_req req);
            logic [ADDR_BITS-1:0] f;
            logic [ADDR_BITS-1:0] l;
            t_rsp                 want;
            int                   hit;
            int                   pos;
            t_range               merged;
            f = req.range_first;
            l = req.range_last;
            want.status     = STATUS_OK;
            want.merge_kind = KIND_NEW;
            hit = -1;
            for (int i = 0; i < ranges.size(); i++) begin
                if (!(l < ranges[i].first || f > ranges[i].last)) begin
                    want.status = STATUS_OVERLAP;
                    break;
                end
            end
            if (want.status == STATUS_OK) begin
                // sums one bit wider so the top address never touches 0
                for (int i = 0; i < ranges.size() && hit < 0; i++) begin
                    if ({1'b0, ranges[i].last} + 17'd1 == {1'b0, f}) begin
                        hit = i;
                        want.merge_kind = KIND_LEFT;
                    end
                end
                for (int i = 0; i < ranges.size() && hit < 0; i++) begin
                    if ({1'b0, l} + 17'd1 == {1'b0, ranges[i].first}) begin
                        hit = i;
                        want.merge_kind = KIND_RIGHT;
                    end
                end
                if (hit >= 0) begin
                    if (want.merge_kind == KIND_LEFT)
                        f = ranges[hit].first;
                    else
                        l = ranges[hit].last;
                    ranges.delete(hit);
                end else if (ranges.size() >= capacity) begin
                    want.status = STATUS_FULL;
                end
                if (want.status == STATUS_OK) begin
                    // equal first addresses: new entry lands after the old ones
                    pos = 0;
                    while (pos < ranges.size() && ranges[pos].first <= f)
                        pos++;
                    merged.first = f;
                    merged.last  = l;
                    ranges.insert(pos, merged);
                end
            end
            want.ranges_held = HELD_BITS'(ranges.size());
            expected.push_back(want);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected.size() == 0) begin
                $error("response transaction with no request pending: %p", got);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.merge_kind !== want.merge_kind) begin
                $error("merge_kind: expected %0d, got %0d", want.merge_kind,
                       got.merge_kind);
                errors++;
            end
            if (got.ranges_held !== want.ranges_held) begin
                $error("ranges_held: expected %0d, got %0d", want.ranges_held,
                       got.ranges_held);
                errors++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_rsp out_data;
    logic out_stall = 1'b0;

    alloc_scoreboard sb = new(MAX_RANGES);

    int burst_left = 0;
    int stall_cycle = 0;
    int stall_run = 0;
    logic stall_hold = 1'b0;

    always #4 clk = ~clk;

    address_range_allocator #(
        .MAX_RANGES(MAX_RANGES)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    // response side: check accepted transactions, stall in shifting moods
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_response(out_data);
        stall_cycle++;
        case (stall_cycle[9:8])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: out_stall <= $urandom_range(0, 1);
            default: begin
                if (stall_run == 0) begin
                    stall_hold = ~stall_hold;
                    stall_run  = $urandom_range(1, 20);
                end else begin
                    stall_run--;
                end
                out_stall <= stall_hold;
            end
        endcase
    end

    task automatic claim(input logic [ADDR_BITS-1:0] f, input logic [ADDR_BITS-1:0] l);
        t_req req;
        int   gap;
        req.range_first = f;
        req.range_last  = l;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                              : $urandom_range(0, 5);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req);
        burst_left--;
    endtask

    // Mostly requests that touch a held range on one side; the rest fill a gap
    // between two, overlap, invert, or land anywhere.
    task automatic random_claim();
        int     pick;
        int     n;
        int     len;
        int     f;
        int     l;
        t_range r;
        pick = $urandom_range(0, 31);
        n    = sb.ranges.size();
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 300)
                                           : $urandom_range(0, 15);
        f = $urandom_range(0, 65535);
        l = $urandom_range(0, 65535);
        if (n > 0) begin
            r = sb.ranges[$urandom_range(0, n - 1)];
            if (pick < 11) begin
                if (r.last != 16'hFFFF) begin
                    f = int'(r.last) + 1;
                    l = (f + len > 65535) ? 65535 : f + len;
                end
            end else if (pick < 20) begin
                if (r.first != 16'h0000) begin
                    l = int'(r.first) - 1;
                    f = (l < len) ? 0 : l - len;
                end
            end else if (pick < 21) begin
                pick = $urandom_range(0, n - 1);
                if (pick < n - 1 && sb.ranges[pick].last != 16'hFFFF
                        && sb.ranges[pick + 1].first != 16'h0000) begin
                    f = int'(sb.ranges[pick].last) + 1;
                    l = int'(sb.ranges[pick + 1].first) - 1;
                end
            end else if (pick < 25) begin
                f = (r.first <= r.last) ? $urandom_range(int'(r.first), int'(r.last))
                                        : int'(r.first);
                l = (f + len > 65535) ? 65535 : f + len;
            end else if (pick < 28) begin
                if (f < l) begin
                    len = f;
                    f   = l;
                    l   = len;
                end
            end
        end
        claim(f[ADDR_BITS-1:0], l[ADDR_BITS-1:0]);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        claim(16'd0, 16'd0);
        claim(16'hFFFF, 16'hFFFF);          // top address is not next to 0
        claim(16'd5, 16'd10);
        claim(16'd11, 16'd20);              // joins left
        claim(16'd1, 16'd4);                // both sides touch: left wins
        claim(16'd3, 16'd3);                // overlap
        claim(16'd30, 16'd25);              // inverted, stored as is
        claim(16'd30, 16'd40);              // same first address as a held one
        claim(16'hFFFE, 16'hFFFE);          // joins right
        claim(16'd26, 16'd29);              // joins the inverted entry, reorders
        for (int k = 1; k <= 11; k++)
            claim(16'(5000 * k + 100), 16'(5000 * k + 100 + k));
        claim(16'd60000, 16'd60000);        // table full
        claim(16'd0, 16'hFFFF);             // overlap wins over full
        claim(16'd41, 16'd50);              // merge still allowed when full
        claim(16'd65530, 16'd65533);

        repeat (850)
            random_claim();

        @(posedge clk);
        in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/ara_pkg.sv
rtl/ara_dp.sv
rtl/ara_ctrl.sv
rtl/address_range_allocator.sv
bench/tb.sv
